// File: rtl/float_fixed_q24_8_converter_top_assert.svh
// assertion macros for the fixed point converter
`ifndef FLOAT_FIXED_Q24_8_CONVERTER_TOP_ASSERT_SVH
`define FLOAT_FIXED_Q24_8_CONVERTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FFC_ASSERT_IMPL(label, clk, rst_n, cond, consq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
        else $error("assertion failed");
`define FFC_ASSERT_NEXT(label, clk, rst_n, cond, consq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
        else $error("assertion failed");
`else
`define FFC_ASSERT_IMPL(label, clk, rst_n, cond, consq)
`define FFC_ASSERT_NEXT(label, clk, rst_n, cond, consq)
`endif
`endif

// File: rtl/ffc_pkg.sv
// shared types and constants for the fixed point converter
package ffc_pkg;
    localparam int unsigned DefFracBits = 8;
    typedef enum logic [1:0] {
        FUNC_INT2FIX   = 2'd0,
        FUNC_FLT2FIX   = 2'd1,
        FUNC_FIX2INT   = 2'd2,
        FUNC_FIX2FLT   = 2'd3
    } t_func;
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_NAN  = 2'd2
    } t_status;
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] operand;
    } t_in;
    typedef struct packed {
        logic [31:0] result;
        logic [1:0]  status;
    } t_out;
endpackage

// File: rtl/ffc_if.sv
// valid/ready channel interface
interface ffc_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/float_fixed_q24_8_converter_top.sv
// result is registered through three register stages before it is valid at the output
// throughput: one transaction per cycle while the output is not stalled, through three register stages
// stalls at the output hold the full stages; empty stages still fill, nothing dropped
// synchronous active low reset clears all stage valid bits
// no stored state beyond the pipeline
module float_fixed_q24_8_converter_top #(
    parameter int unsigned FRAC_BITS = ffc_pkg::DefFracBits
) (
    input logic i_clk,
    input logic i_rst_n,
    ffc_if.sink   i_in,
    ffc_if.source o_out
);
    import ffc_pkg::*;
    `include "float_fixed_q24_8_converter_top_assert.svh"

    t_in  c_in;
    t_out c_out;
    assign c_in = i_in.data;
    assign o_out.data = c_out;

    ffc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_data  (c_in),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (c_out)
    );

    `FFC_ASSERT_IMPL(a_status_legal, i_clk, i_rst_n, o_out.valid, c_out.status != 2'd3)
    `FFC_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid && $stable(c_out))
    `FFC_ASSERT_IMPL(a_ready_when_drain, i_clk, i_rst_n, o_out.ready, i_in.ready)
endmodule

// File: rtl/ffc_datapath.sv
// three stage conversion datapath with stall control
module ffc_datapath #(
    parameter int unsigned FRAC_BITS = ffc_pkg::DefFracBits
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ffc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ffc_pkg::t_out o_data
);
    import ffc_pkg::*;

    // stage 1 registers
    logic        r_v1;
    logic [1:0]  r_f1;
    logic [31:0] r_op1;
    logic        r_sg1;
    logic [31:0] r_mag1;
    logic [23:0] r_m1;
    logic signed [9:0] r_s1;
    logic        r_nan1, r_inf1;
    // stage 2 registers
    logic        r_v2;
    logic [1:0]  r_f2;
    logic [31:0] r_op2;
    logic        r_sg2;
    logic [32:0] r_fmag2;
    logic        r_nan2, r_inf2;
    logic [31:0] r_mag2;
    logic [4:0]  r_p2;
    // stage 3
    logic        r_v3;
    t_out        r_out3;

    logic en1, en2, en3;
    assign en3 = !r_v3 || i_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_data  = r_out3;

    // stage 1 decode
    logic [7:0]  c_e;
    logic [23:0] c_m;
    logic signed [9:0] c_s;
    always_comb begin
        c_e = i_data.operand[30:23];
        c_m = {(c_e != 8'd0), i_data.operand[22:0]};
        c_s = $signed({2'b00, ((c_e == 8'd0) ? 8'd1 : c_e)}) - 10'sd150
            + $signed(10'(FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_f1   <= i_data.func;
            r_op1  <= i_data.operand;
            r_sg1  <= i_data.operand[31];
            r_mag1 <= i_data.operand[31] ? (32'd0 - i_data.operand) : i_data.operand;
            r_m1   <= c_m;
            r_s1   <= c_s;
            r_nan1 <= (c_e == 8'hFF) && (i_data.operand[22:0] != 23'd0);
            r_inf1 <= (c_e == 8'hFF) && (i_data.operand[22:0] == 23'd0);
        end
    end

    // stage 2: shift for float to fixed, leading one for fixed to float
    logic [32:0] c_fmag;
    logic [4:0]  c_p;
    logic [4:0]  c_sh;
    logic [24:0] c_rnd;
    always_comb begin
        c_fmag = '0;
        c_sh   = 5'(-r_s1);
        c_rnd  = 25'(r_m1) + (25'd1 << (c_sh - 5'd1));
        if (r_m1 == 24'd0) begin
            c_fmag = '0;
        end else if (r_s1 >= 0) begin
            if (r_s1 > 10'sd31) c_fmag = 33'h1_0000_0000;
            else c_fmag = (33'(r_m1) << r_s1[4:0]) | ((r_s1 > 10'sd9) &&
                ((64'(r_m1) << r_s1[4:0]) >> 33) != 64'd0 ? 33'h1_0000_0000 : 33'd0);
        end else if (r_s1 < -10'sd25) begin
            c_fmag = '0;
        end else begin
            c_fmag = 33'(c_rnd >> c_sh);
        end
        c_p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (r_mag1[i]) c_p = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_f2    <= r_f1;
            r_op2   <= r_op1;
            r_sg2   <= r_sg1;
            r_fmag2 <= c_fmag;
            r_nan2  <= r_nan1;
            r_inf2  <= r_inf1;
            r_mag2  <= r_mag1;
            r_p2    <= c_p;
        end
    end

    // stage 3: finish each operation
    t_out        n_out;
    logic [32:0] c_lim;
    logic [32:0] c_sat;
    logic [31:0] c_nrm;
    logic [4:0]  c_rsh;
    logic [31:0] c_rem, c_half;
    logic [24:0] c_q;
    logic [5:0]  c_pp;
    logic [7:0]  c_bexp;
    logic signed [63:0] c_prod;
    always_comb begin
        n_out  = '0;
        c_lim  = r_sg2 ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        c_sat  = (r_fmag2 > c_lim) ? c_lim : r_fmag2;
        c_rsh  = r_p2 - 5'd23;
        c_rem  = r_mag2 & ((32'd1 << c_rsh) - 32'd1);
        c_half = 32'd1 << (c_rsh - 5'd1);
        c_nrm  = 32'd0;
        c_q    = 25'd0;
        c_pp   = {1'b0, r_p2};
        c_prod = $signed({{32{r_op2[31]}}, r_op2}) <<< FRAC_BITS;
        if (r_p2 <= 5'd23) begin
            c_q = 25'(r_mag2 << (5'd23 - r_p2));
        end else begin
            c_nrm = r_mag2 >> c_rsh;
            c_q   = 25'(c_nrm);
            if (c_rem > c_half || (c_rem == c_half && c_nrm[0])) c_q = c_q + 25'd1;
            if (c_q[24]) begin
                c_q  = c_q >> 1;
                c_pp = c_pp + 6'd1;
            end
        end
        c_bexp = 8'(c_pp) + 8'd127 - 8'(FRAC_BITS);
        case (t_func'(r_f2))
            FUNC_INT2FIX: begin
                n_out.result = r_op2 << FRAC_BITS;
                n_out.status = (c_prod > 64'sh7FFF_FFFF || c_prod < -64'sh8000_0000)
                    ? ST_OVF : ST_OK;
            end
            FUNC_FLT2FIX: begin
                if (r_nan2) begin
                    n_out.result = '0;
                    n_out.status = ST_NAN;
                end else if (r_inf2) begin
                    n_out.result = r_sg2 ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    n_out.status = ST_OVF;
                end else begin
                    n_out.result = r_sg2 ? 32'(33'd0 - c_sat) : c_sat[31:0];
                    n_out.status = (r_fmag2 > c_lim) ? ST_OVF : ST_OK;
                end
            end
            FUNC_FIX2INT: begin
                n_out.result = 32'($signed(r_op2) >>> FRAC_BITS);
                n_out.status = ST_OK;
            end
            default: begin
                n_out.result = (r_mag2 == 32'd0) ? 32'd0 :
                    {r_sg2, c_bexp, c_q[22:0]};
                n_out.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en3) r_out3 <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end
endmodule
